// File: design/plb_pkg.sv
// Shared types and codes for the positional list buffer.
`timescale 1ns / 1ps
package plb_pkg;

	localparam int VAL_W   = 32;
	localparam int POS_W   = 8;
	localparam int CMD_W   = 3;
	localparam int ST_W    = 2;
	localparam int OCNT_W  = 5;
	localparam int GRP     = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_INS_TAIL = 3'd0,
		CMD_REM_TAIL = 3'd1,
		CMD_INS_HEAD = 3'd2,
		CMD_REM_HEAD = 3'd3,
		CMD_INS_POS  = 3'd4,
		CMD_REM_POS  = 3'd5
	} cmd_e;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INS  = 2'd1,
		CELL_REM  = 2'd2
	} cell_op_t;

	typedef struct packed {
		logic [CMD_W-1:0]        command;
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        position;
	} plb_in_t;

	typedef struct packed {
		logic [ST_W-1:0]         status;
		logic signed [VAL_W-1:0] removed_value;
		logic [OCNT_W-1:0]       entry_count;
	} plb_out_t;

	typedef struct packed {
		cell_op_t op;
		status_t  status;
	} plb_ctl_t;

endpackage

// File: design/positional_list_buffer_core.sv
// Top level: chain of list cells, command decode and result register.
//
//  channel | direction | payload  | handshake
//  cmd     | in        | plb_in_t  | cmd_valid / cmd_ready
//  res     | out       | plb_out_t | res_valid / res_ready
//
// For each request the cells shift at the accept edge while the removed slot is
// captured per group of 16 cells; the next cycle ORs the groups into the result
// register. A new request is taken when no request is in flight and the result
// register is empty or being drained.
// Reset clears the count and handshake flags; entry contents are left as is.
// A stalled result holds cmd_ready low.
`timescale 1ns / 1ps
module positional_list_buffer_core #(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  plb_pkg::plb_in_t cmd,
	output logic             res_valid,
	input  logic             res_ready,
	output plb_pkg::plb_out_t res
);
	import plb_pkg::*;

	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH+1);
	localparam int GROUPS = (DEPTH + GRP - 1) / GRP;

	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_nxt;
	logic [IDX_W-1:0]       slot;
	plb_ctl_t               ctl;
	logic                   accept;
	logic                   pend_q;
	logic                   res_valid_q;
	plb_out_t               res_q;
	status_t                status_s1;
	logic [CNT_W-1:0]       count_s1;
	logic signed [VAL_W-1:0] cell_val [DEPTH];
	logic signed [VAL_W-1:0] left_v   [DEPTH];
	logic signed [VAL_W-1:0] right_v  [DEPTH];
	logic signed [VAL_W-1:0] taps     [DEPTH];
	logic signed [VAL_W-1:0] grp_or   [GROUPS];
	logic signed [VAL_W-1:0] grp_s1   [GROUPS];
	logic signed [VAL_W-1:0] removed;

	assign cmd_ready = !pend_q && (!res_valid_q || res_ready);
	assign accept    = cmd_valid && cmd_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	plb_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.cmd       (cmd),
		.count     (count_q),
		.ctl       (ctl),
		.slot      (slot),
		.count_nxt (count_nxt)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign left_v[i] = cell_val[i];
		end else begin : g_left
			assign left_v[i] = cell_val[i-1];
		end
		if (i == DEPTH-1) begin : g_last
			assign right_v[i] = cell_val[i];
		end else begin : g_right
			assign right_v[i] = cell_val[i+1];
		end

		plb_cell #(.DEPTH(DEPTH), .IDX(i)) u_cell (
			.clk       (clk),
			.en        (accept),
			.op        (ctl.op),
			.slot      (slot),
			.new_val   (cmd.value),
			.left_val  (left_v[i]),
			.right_val (right_v[i]),
			.val       (cell_val[i]),
			.tap       (taps[i])
		);
	end

	// first reduction level: 16 cells per group
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			grp_or[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				if (g*GRP + k < DEPTH) grp_or[g] = grp_or[g] | taps[g*GRP + k];
			end
		end
	end

	always_comb begin
		removed = '0;
		for (int g = 0; g < GROUPS; g++) removed = removed | grp_s1[g];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			grp_s1    <= grp_or;
			status_s1 <= ctl.status;
			count_s1  <= count_nxt;
		end
		if (pend_q) begin
			res_q.status        <= status_s1;
			res_q.removed_value <= removed;
			res_q.entry_count   <= OCNT_W'(count_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			pend_q <= accept;
			if (accept) count_q <= count_nxt;
			if (pend_q) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

endmodule

// File: design/plb_cell.sv
// One list slot: holds an entry and shifts toward either neighbor.
`timescale 1ns / 1ps
module plb_cell #(
	parameter int DEPTH = 16,
	parameter int IDX   = 0
) (
	input  logic                         clk,
	input  logic                         en,
	input  plb_pkg::cell_op_t            op,
	input  logic [$clog2(DEPTH)-1:0]     slot,
	input  logic signed [plb_pkg::VAL_W-1:0] new_val,
	input  logic signed [plb_pkg::VAL_W-1:0] left_val,
	input  logic signed [plb_pkg::VAL_W-1:0] right_val,
	output logic signed [plb_pkg::VAL_W-1:0] val,
	output logic signed [plb_pkg::VAL_W-1:0] tap
);
	import plb_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [IDX_W-1:0] ME = IDX_W'(IDX);

	logic signed [VAL_W-1:0] val_q;
	logic                    hit;
	logic                    above;

	assign hit   = (slot == ME);
	assign above = (ME > slot);
	assign val   = val_q;
	// only the removed slot shows its value; others read zero for the OR tree
	assign tap   = (hit && op == CELL_REM) ? val_q : '0;

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (op)
				CELL_INS: begin
					if (hit) val_q <= new_val;
					else if (above) val_q <= left_val;
				end
				CELL_REM: begin
					if (hit || above) val_q <= right_val;
				end
				default: ;
			endcase
		end
	end

endmodule

// File: design/plb_ctrl.sv
// Command decode: target slot, cell operation, status and next count.
`timescale 1ns / 1ps
module plb_ctrl #(
	parameter int DEPTH = 16
) (
	input  plb_pkg::plb_in_t               cmd,
	input  logic [$clog2(DEPTH+1)-1:0]     count,
	output plb_pkg::plb_ctl_t              ctl,
	output logic [$clog2(DEPTH)-1:0]       slot,
	output logic [$clog2(DEPTH+1)-1:0]     count_nxt
);
	import plb_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH+1);
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
	localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

	logic [CMP_W-1:0] pos_w;
	logic [CMP_W-1:0] cnt_w;
	logic [CMP_W-1:0] pos_m1;
	logic [CMP_W-1:0] cnt_m1;
	logic             is_ins;
	logic             is_rem;
	logic             head;

	always_comb begin
		pos_w  = CMP_W'(cmd.position);
		cnt_w  = CMP_W'(count);
		pos_m1 = pos_w - CMP_W'(1);
		cnt_m1 = cnt_w - CMP_W'(1);
		is_ins = 1'b0;
		is_rem = 1'b0;
		head   = 1'b0;
		unique case (cmd_e'(cmd.command))
			CMD_INS_TAIL: is_ins = 1'b1;
			CMD_INS_HEAD: begin is_ins = 1'b1; head = 1'b1; end
			CMD_INS_POS:  is_ins = 1'b1;
			CMD_REM_TAIL: is_rem = 1'b1;
			CMD_REM_HEAD: begin is_rem = 1'b1; head = 1'b1; end
			CMD_REM_POS:  is_rem = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		ctl.op     = CELL_HOLD;
		ctl.status = ST_OK;
		slot       = '0;
		count_nxt  = count;
		if (is_ins) begin
			if (count == FULL) begin
				ctl.status = ST_FULL;
			end else begin
				ctl.op    = CELL_INS;
				count_nxt = count + CNT_W'(1);
				priority if (cmd_e'(cmd.command) == CMD_INS_TAIL) slot = IDX_W'(cnt_w);
				else if (head || pos_w <= CMP_W'(1))              slot = '0;
				else if (pos_w > cnt_w + CMP_W'(1))               slot = IDX_W'(cnt_w);
				else                                              slot = IDX_W'(pos_m1);
			end
		end else if (is_rem) begin
			if (count == '0) begin
				ctl.status = ST_EMPTY;
			end else begin
				ctl.op    = CELL_REM;
				count_nxt = count - CNT_W'(1);
				priority if (cmd_e'(cmd.command) == CMD_REM_TAIL) slot = IDX_W'(cnt_m1);
				else if (head || pos_w <= CMP_W'(1))              slot = '0;
				else if (pos_w > cnt_w)                           slot = IDX_W'(cnt_m1);
				else                                              slot = IDX_W'(pos_m1);
			end
		end
	end

endmodule
